>>> src/assert_macros.svh
// Assertion macros used by the modulator RTL.
// Needs a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant violated");

// A consequence that holds in the same cycle as its cause.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// A consequence that holds in the cycle after its cause.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

>>> src/dabtps_pkg.sv
// Types, widths and register codes of the triple-phase-shift modulator.
// No dependencies; the channel interfaces and the modules use it by scoped names.
package dabtps_pkg;

    localparam int DUTY_BITS   = 12;
    localparam int OFFSET_BITS = 11;
    localparam int PHASE_BITS  = 16;
    localparam int HALF_BITS   = 11;
    localparam int MID_BITS    = 11;
    localparam int MARGIN_BITS = 6;
    localparam int TRIG_BITS   = 8;
    localparam int TRANS_BITS  = 12;
    localparam int CMP_BITS    = 16;

    // Fraction scale of every offset sum, and the width of the multiplicand.
    localparam int FRAC_SHIFT = DUTY_BITS + 16;
    localparam int XW         = DUTY_BITS + 19;
    localparam int PW         = XW + PHASE_BITS;
    localparam int MUL_STEPS  = PHASE_BITS;
    localparam int CNT_BITS   = $clog2(MUL_STEPS);

    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_BITS-1:0] REG_HALF_PERIOD = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MIDPOINT    = 4'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MARGIN      = 4'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TRIG_OFFSET = 4'd3;

    localparam logic [HALF_BITS-1:0]   HALF_RESET   = 11'd450;
    localparam logic [MID_BITS-1:0]    MID_RESET    = 11'd448;
    localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = 6'd3;
    localparam logic [TRIG_BITS-1:0]   TRIG_RESET   = 8'd10;
    localparam logic [OFFSET_BITS-1:0] PREV_RESET   = 11'd449;

    typedef logic [OFFSET_BITS-1:0] leg_t;
    typedef logic [XW-1:0]          mcand_t;
    typedef logic [PW-1:0]          prod_t;

    typedef struct packed {
        logic [DUTY_BITS-1:0]         duty_primary;
        logic [DUTY_BITS-1:0]         duty_secondary;
        logic signed [PHASE_BITS-1:0] phase_command;
    } in_item_t;

    typedef struct packed {
        leg_t                  primary_leg_a;
        leg_t                  primary_leg_b;
        leg_t                  secondary_leg_a;
        leg_t                  secondary_leg_b;
        logic [TRANS_BITS-1:0] transition_primary_a;
        logic [TRANS_BITS-1:0] transition_primary_b;
        logic [TRANS_BITS-1:0] transition_secondary_a;
        logic [TRANS_BITS-1:0] transition_secondary_b;
        logic [CMP_BITS-1:0]   trigger_compare;
    } out_item_t;

    typedef struct packed {
        logic [HALF_BITS-1:0]   half_period;
        logic [MID_BITS-1:0]    transition_midpoint;
        logic [MARGIN_BITS-1:0] transition_margin;
        logic [TRIG_BITS-1:0]   trigger_offset;
    } cfg_t;

    typedef struct packed {
        leg_t prev_pa;
        leg_t prev_pb;
        leg_t prev_sa;
        leg_t prev_sb;
    } prev_t;

endpackage

>>> src/dabtps_in_if.sv
// Request channel carrying one set of duty codes and a phase command.
// Depends on dabtps_pkg for the payload type.
interface dabtps_in_if;
    logic                 valid;
    logic                 ready;
    dabtps_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> src/dabtps_out_if.sv
// Result channel carrying leg offsets, transition and trigger compares.
// Depends on dabtps_pkg for the payload type.
interface dabtps_out_if;
    logic                  valid;
    logic                  ready;
    dabtps_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> src/dabtps_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on dabtps_pkg for the field widths.
interface dabtps_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [dabtps_pkg::CFG_INDEX_BITS-1:0]  index;
    logic [dabtps_pkg::CFG_DATA_BITS-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/dabtps_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on dabtps_pkg for widths.
module dabtps_mul (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  dabtps_pkg::mcand_t                  mcand,
    input  logic [dabtps_pkg::PHASE_BITS-1:0]   mplier,
    output dabtps_pkg::prod_t                   prod,
    output logic                                busy,
    output logic                                done
);

    dabtps_pkg::prod_t                  acc_reg;
    dabtps_pkg::prod_t                  mcand_reg;
    logic [dabtps_pkg::PHASE_BITS-1:0]  mplier_reg;
    logic [dabtps_pkg::CNT_BITS-1:0]    cnt_reg;
    logic                               busy_reg;
    logic                               done_reg;

    // Control: step counter, busy and done flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == dabtps_pkg::CNT_BITS'(dabtps_pkg::MUL_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath: add the shifted multiplicand for each set multiplier bit.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= dabtps_pkg::prod_t'(mcand);
            mplier_reg <= mplier;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign prod = acc_reg;
    assign busy = busy_reg;
    assign done = done_reg;

endmodule

>>> src/dabtps_fin.sv
// Offset finishing: truncation, saturation, zero avoidance, transitions, trigger.
// Depends on dabtps_pkg for types and widths.
module dabtps_fin (
    input  dabtps_pkg::prod_t     prod_pa,
    input  dabtps_pkg::prod_t     prod_pb,
    input  dabtps_pkg::prod_t     prod_sa,
    input  dabtps_pkg::prod_t     prod_sb,
    input  dabtps_pkg::prev_t     prev,
    input  dabtps_pkg::cfg_t      cfg,
    output dabtps_pkg::out_item_t result
);

    localparam int VW = dabtps_pkg::PW - dabtps_pkg::FRAC_SHIFT;
    localparam dabtps_pkg::leg_t LEG_MAX = '1;

    // Drop the fraction and saturate at the top offset code.
    function automatic dabtps_pkg::leg_t to_offset(input dabtps_pkg::prod_t p);
        logic [VW-1:0] v;
        v = p[dabtps_pkg::PW-1:dabtps_pkg::FRAC_SHIFT];
        if (|v[VW-1:dabtps_pkg::OFFSET_BITS])
            return LEG_MAX;
        else
            return v[dabtps_pkg::OFFSET_BITS-1:0];
    endfunction

    // Transition compare from the new and previous offset around the midpoint.
    function automatic logic [dabtps_pkg::TRANS_BITS-1:0] transition(
        input dabtps_pkg::leg_t                   x,
        input dabtps_pkg::leg_t                   m,
        input logic [dabtps_pkg::MID_BITS-1:0]    mid,
        input logic [dabtps_pkg::MARGIN_BITS-1:0] margin
    );
        logic [dabtps_pkg::TRANS_BITS-1:0] t;
        if (x >= mid && m <= mid)
            t = dabtps_pkg::TRANS_BITS'(x) + dabtps_pkg::TRANS_BITS'(margin);
        else if (x <= mid && m >= mid)
            t = (m >= dabtps_pkg::OFFSET_BITS'(margin))
                ? dabtps_pkg::TRANS_BITS'(m - dabtps_pkg::OFFSET_BITS'(margin)) : '0;
        else
            t = dabtps_pkg::TRANS_BITS'(mid);
        return t;
    endfunction

    function automatic dabtps_pkg::leg_t bump(input dabtps_pkg::leg_t v, input logic any_zero);
        return (any_zero && v != LEG_MAX) ? v + 1'b1 : v;
    endfunction

    dabtps_pkg::leg_t sat_pa, sat_pb, sat_sa, sat_sb;
    dabtps_pkg::leg_t pa, pb, sa, sb;
    logic             any_zero;

    assign sat_pa = to_offset(prod_pa);
    assign sat_pb = to_offset(prod_pb);
    assign sat_sa = to_offset(prod_sa);
    assign sat_sb = to_offset(prod_sb);

    // A zero offset on any leg moves every leg below the top offset code up by one.
    assign any_zero = (sat_pa == '0) || (sat_pb == '0) || (sat_sa == '0) || (sat_sb == '0);
    assign pa = bump(sat_pa, any_zero);
    assign pb = bump(sat_pb, any_zero);
    assign sa = bump(sat_sa, any_zero);
    assign sb = bump(sat_sb, any_zero);

    // Assemble the result item.
    always_comb
    begin
        result.primary_leg_a          = pa;
        result.primary_leg_b          = pb;
        result.secondary_leg_a        = sa;
        result.secondary_leg_b        = sb;
        result.transition_primary_a   = transition(pa, prev.prev_pa,
                                          cfg.transition_midpoint, cfg.transition_margin);
        result.transition_primary_b   = transition(pb, prev.prev_pb,
                                          cfg.transition_midpoint, cfg.transition_margin);
        result.transition_secondary_a = transition(sa, prev.prev_sa,
                                          cfg.transition_midpoint, cfg.transition_margin);
        result.transition_secondary_b = transition(sb, prev.prev_sb,
                                          cfg.transition_midpoint, cfg.transition_margin);
        result.trigger_compare        = dabtps_pkg::CMP_BITS'({cfg.half_period, 1'b0})
                                      - dabtps_pkg::CMP_BITS'(sb)
                                      - dabtps_pkg::CMP_BITS'(cfg.trigger_offset);
    end

endmodule

>>> src/dab_triple_phase_shift_modulator_unit.sv
// Top level of the dual active bridge triple-phase-shift modulator.
// Depends on dabtps_pkg, the channel interfaces, dabtps_mul, dabtps_fin, assert_macros.svh.
//
//   channel | direction | carries
//   cmd     | in        | duty_primary, duty_secondary, phase_command
//   rsp     | out       | four leg offsets, four transition compares, trigger compare
//   cfg     | in        | register index and write data, always ready
//
// An item passes from acceptance through a setup state, the phase product on the
// bit-serial multiplier of lane 0, the four leg products in parallel lanes, and a hold
// state that loads the output register once it is free. A new request is taken once the
// previous result is loaded; a result waiting in the output register does not block the next
// request until that request is finished. Reset restores register defaults and the
// previous offsets.
`include "assert_macros.svh"

module dab_triple_phase_shift_modulator_unit (
    input  logic          clk,
    input  logic          rst_n,
    dabtps_in_if.sink     cmd,
    dabtps_out_if.source  rsp,
    dabtps_cfg_if.sink    cfg
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PREP  = 5'b00010,
        ST_SHIFT = 5'b00100,
        ST_LEGS  = 5'b01000,
        ST_HOLD  = 5'b10000
    } state_t;

    localparam logic [dabtps_pkg::DUTY_BITS:0] DUTY_ONE =
        {1'b1, {dabtps_pkg::DUTY_BITS{1'b0}}};

    state_t                 state_reg, state_next;
    dabtps_pkg::cfg_t       cfg_reg;
    dabtps_pkg::prev_t      prev_reg;
    dabtps_pkg::in_item_t   item_reg;
    dabtps_pkg::out_item_t  out_reg;
    logic                   out_valid_reg;

    logic                   accept;
    logic                   load;
    logic [3:0]             lane_start;
    logic [3:0]             lane_busy;
    logic [3:0]             lane_done;
    dabtps_pkg::prod_t      lane_prod [4];
    dabtps_pkg::mcand_t     lane_mcand [4];
    logic [dabtps_pkg::PHASE_BITS-1:0] lane_mplier [4];
    dabtps_pkg::out_item_t  result;

    // Configuration registers.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_period         <= dabtps_pkg::HALF_RESET;
            cfg_reg.transition_midpoint <= dabtps_pkg::MID_RESET;
            cfg_reg.transition_margin   <= dabtps_pkg::MARGIN_RESET;
            cfg_reg.trigger_offset      <= dabtps_pkg::TRIG_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                dabtps_pkg::REG_HALF_PERIOD:
                    cfg_reg.half_period <= cfg.data[dabtps_pkg::HALF_BITS-1:0];
                dabtps_pkg::REG_MIDPOINT:
                    cfg_reg.transition_midpoint <= cfg.data[dabtps_pkg::MID_BITS-1:0];
                dabtps_pkg::REG_MARGIN:
                    cfg_reg.transition_margin <= cfg.data[dabtps_pkg::MARGIN_BITS-1:0];
                dabtps_pkg::REG_TRIG_OFFSET:
                    cfg_reg.trigger_offset <= cfg.data[dabtps_pkg::TRIG_BITS-1:0];
                default:
                    ;
            endcase
        end
    end

    // Sequencer.
    assign cmd.ready = (state_reg == ST_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign load      = (state_reg == ST_HOLD) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_PREP;
            ST_PREP:  state_next = ST_SHIFT;
            ST_SHIFT: if (lane_done[0]) state_next = ST_LEGS;
            ST_LEGS:  if (lane_done[0]) state_next = ST_HOLD;
            ST_HOLD:  if (load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= cmd.data;
    end

    // Branch selection and the multiplicands of each leg.
    logic [dabtps_pkg::DUTY_BITS-1:0]  c1, c2;
    logic [dabtps_pkg::DUTY_BITS:0]    csum;
    logic [dabtps_pkg::PHASE_BITS-1:0] mag;
    logic                              negative, wide;
    dabtps_pkg::mcand_t                scale, shift_prod;
    dabtps_pkg::mcand_t                inv1, inv2, hsum, hd12, hd21;
    dabtps_pkg::mcand_t                p1, p2, s1, s2;

    always_comb
    begin
        c1       = item_reg.duty_primary;
        c2       = item_reg.duty_secondary;
        csum     = {1'b0, c1} + {1'b0, c2};
        negative = item_reg.phase_command[dabtps_pkg::PHASE_BITS-1];
        mag      = negative ? (~item_reg.phase_command + 1'b1) : item_reg.phase_command;
        wide     = (csum >= DUTY_ONE);
        scale    = wide ? (dabtps_pkg::mcand_t'(1) << (dabtps_pkg::DUTY_BITS + 2))
                        : (dabtps_pkg::mcand_t'(csum) << 2);
        shift_prod = lane_prod[0][dabtps_pkg::XW-1:0];

        inv1 = dabtps_pkg::mcand_t'(DUTY_ONE - {1'b0, c1}) << 16;
        inv2 = dabtps_pkg::mcand_t'(DUTY_ONE - {1'b0, c2}) << 16;
        hsum = dabtps_pkg::mcand_t'({DUTY_ONE, 1'b0} - {2'b0, c1} - {2'b0, c2}) << 15;
        hd12 = (c1 >= c2) ? (dabtps_pkg::mcand_t'(c1 - c2) << 15) : '0;
        hd21 = (c2 >= c1) ? (dabtps_pkg::mcand_t'(c2 - c1) << 15) : '0;

        if (c1 == c2)
        begin
            p1 = '0;   p2 = inv1; s1 = '0;   s2 = inv1;
        end
        else if (c1 > c2)
        begin
            p1 = hd12; p2 = wide ? hsum : (inv1 + hd12); s1 = '0; s2 = inv2;
        end
        else
        begin
            p1 = '0;   p2 = inv1; s1 = hd21; s2 = wide ? hsum : (inv2 + hd21);
        end

        // Lane 0 first forms the phase product, then all lanes form leg products.
        lane_start[0] = (state_reg == ST_PREP) || ((state_reg == ST_SHIFT) && lane_done[0]);
        for (int i = 1; i < 4; i++)
            lane_start[i] = (state_reg == ST_SHIFT) && lane_done[0];

        lane_mcand[0] = (state_reg == ST_PREP) ? scale
                                               : (negative ? p1 : p1 + shift_prod);
        lane_mcand[1] = negative ? p2 : p2 + shift_prod;
        lane_mcand[2] = negative ? s1 + shift_prod : s1;
        lane_mcand[3] = negative ? s2 + shift_prod : s2;

        lane_mplier[0] = (state_reg == ST_PREP) ? mag
                                                : dabtps_pkg::PHASE_BITS'(cfg_reg.half_period);
        for (int i = 1; i < 4; i++)
            lane_mplier[i] = dabtps_pkg::PHASE_BITS'(cfg_reg.half_period);
    end

    // Four multiplier lanes.
    for (genvar g = 0; g < 4; g++)
    begin : g_lane
        dabtps_mul u_mul (
            .clk    (clk),
            .rst_n  (rst_n),
            .start  (lane_start[g]),
            .mcand  (lane_mcand[g]),
            .mplier (lane_mplier[g]),
            .prod   (lane_prod[g]),
            .busy   (lane_busy[g]),
            .done   (lane_done[g])
        );
    end

    dabtps_fin u_fin (
        .prod_pa (lane_prod[0]),
        .prod_pb (lane_prod[1]),
        .prod_sa (lane_prod[2]),
        .prod_sb (lane_prod[3]),
        .prev    (prev_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    // Previous offsets and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= {4{dabtps_pkg::PREV_RESET}};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                prev_reg.prev_pa <= result.primary_leg_a;
                prev_reg.prev_pb <= result.primary_leg_b;
                prev_reg.prev_sa <= result.secondary_leg_a;
                prev_reg.prev_sb <= result.secondary_leg_b;
                out_valid_reg    <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= result;
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    // Checks on the sequencing of the lanes and the output register.
    `ASSERT_IMPLIES(a_ready_lanes_free, cmd.ready, lane_busy == 4'b0000)
    `ASSERT_ALWAYS(a_leg_lanes_sync, lane_done[1] == lane_done[2] && lane_done[2] == lane_done[3])
    `ASSERT_NEXT(a_load_shows_result, load, rsp.valid && state_reg == ST_IDLE)

endmodule
